FILE: hdl/rc4kg_pkg.sv
`timescale 1ns / 1ps

package rc4kg_pkg;

  // default store sizes
  localparam int MAX_PERM_DEF = 256;
  localparam int MAX_KEY_DEF  = 256;

  // width of the sums that get reduced modulo n (at most 3 * 255)
  localparam int XW = 10;
  // width of the size and length registers
  localparam int NW = 9;
  // width of the schedule round count
  localparam int RW = 16;
  // apb address and data widths
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  // stream data widths
  localparam int IN_DW  = 24;
  localparam int OUT_DW = 8;

  // item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_GEN   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PERM_SIZE = 2'd0;
  localparam logic [1:0] REG_ROUNDS    = 2'd1;
  localparam logic [1:0] REG_KEY_LEN   = 2'd2;

  // iterative modulo: quotient bits handled per cycle and cycles per reduction
  localparam int MOD_BITS_PER_CYC = 3;
  localparam int MOD_CYCLES       = 3;

  // one restoring step: subtract n shifted by k when it fits
  function automatic logic [XW-1:0] mod_sub(input logic [XW-1:0] rem,
                                            input logic [NW-1:0] n,
                                            input int k);
    logic [XW+NW-1:0] d;
    logic [XW+NW-1:0] r;
    d = (XW+NW)'(n) << k;
    r = (XW+NW)'(rem);
    if (r >= d) begin
      return XW'(r - d);
    end
    return rem;
  endfunction

  // single compare and subtract, exact when x < 2n
  function automatic logic [XW-1:0] mod_fold(input logic [XW-1:0] x,
                                             input logic [NW-1:0] n);
    logic [XW-1:0] xn;
    xn = XW'(n);
    if (x >= xn) begin
      return x - xn;
    end
    return x;
  endfunction

endpackage

FILE: hdl/rc4_keystream_generator_core.sv
`timescale 1ns / 1ps

// Generalized RC4 keystream generator with permutation size N and T schedule rounds.
// Input stream: one item per transfer; in_tdata carries opcode, key index and key value.
//   load (opcode 0) writes one key element, schedule (opcode 1) fills the permutation
//   with the identity and runs T swap rounds, generate (opcode 2) emits one keystream
//   value on the output stream. Opcode 3 is taken and dropped.
// Steps, all set by the single permutation memory (one read and one write port,
// registered read data) and the iterative modulo unit:
//   load or unused opcode: handled in the idle state alone
//   generate: i step, j sum, read S[j], swap, output read, then the output register;
//   a sum that is 2N or more first goes through the modulo unit (3 quotient bits
//   per cycle), and for the i step a read of S[i] follows it
//   schedule: N fill writes, then per round read S[a], j sum, read S[j], two writes;
//   a round sum of 2N or more first goes through the modulo unit
// Items are taken one at a time; in_tready is high while the sequencer is idle.
// A finished keystream value sits in the output register while the next item is
// taken; a stalled receiver only holds back the next generate item at its last step.
// Reset clears i and j, the sequencer and the output valid flag and loads the default
// register values (N 256, T 256, key length 16). Memories are not cleared: a
// schedule must run before generate, and key elements must be loaded before use.
// Registers: perm_size at 0x0, schedule_rounds at 0x4, key_length at 0x8.
module rc4_keystream_generator_core #(
  parameter int MAX_PERM = rc4kg_pkg::MAX_PERM_DEF,
  parameter int MAX_KEY  = rc4kg_pkg::MAX_KEY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] opcode, [9:2] key_index, [17:10] key_value, [23:18] zero
  input  logic [rc4kg_pkg::IN_DW-1:0]   in_tdata,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] keystream
  output logic [rc4kg_pkg::OUT_DW-1:0]  out_tdata,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc4kg_pkg::CFG_AW-1:0]  paddr,
  input  logic [rc4kg_pkg::CFG_DW-1:0]  pwdata,
  output logic [rc4kg_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready
);
  import rc4kg_pkg::*;

  localparam int PERM_DEPTH = (MAX_PERM < 256) ? MAX_PERM : 256;
  localparam int KEY_DEPTH  = (MAX_KEY < 256) ? MAX_KEY : 256;
  localparam int AW  = $clog2(PERM_DEPTH);
  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_GEN_IRD  = 4'd1;
  localparam logic [3:0] ST_GEN_J    = 4'd2;
  localparam logic [3:0] ST_GEN_JRD  = 4'd3;
  localparam logic [3:0] ST_GEN_SWAP = 4'd4;
  localparam logic [3:0] ST_GEN_T    = 4'd5;
  localparam logic [3:0] ST_GEN_EMIT = 4'd6;
  localparam logic [3:0] ST_SCH_FILL = 4'd7;
  localparam logic [3:0] ST_SCH_RD   = 4'd8;
  localparam logic [3:0] ST_SCH_J    = 4'd9;
  localparam logic [3:0] ST_SCH_JRD  = 4'd10;
  localparam logic [3:0] ST_SCH_SW   = 4'd11;
  localparam logic [3:0] ST_SCH_W2   = 4'd12;
  localparam logic [3:0] ST_MOD      = 4'd13;

  // input fields
  logic [1:0] in_opcode;
  logic [7:0] in_key_index;
  logic [7:0] in_key_value;
  logic       in_xfer;

  assign in_opcode    = in_tdata[1:0];
  assign in_key_index = in_tdata[9:2];
  assign in_key_value = in_tdata[17:10];
  assign in_xfer      = in_tvalid && in_tready;

  // configuration registers
  logic [NW-1:0] perm_size_r;
  logic [RW-1:0] rounds_r;
  logic [NW-1:0] key_len_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_size_r <= NW'(256);
      rounds_r    <= RW'(256);
      key_len_r   <= NW'(16);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PERM_SIZE: perm_size_r <= pwdata[NW-1:0];
        REG_ROUNDS:    rounds_r    <= pwdata[RW-1:0];
        REG_KEY_LEN:   key_len_r   <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_PERM_SIZE: prdata = CFG_DW'(perm_size_r);
      REG_ROUNDS:    prdata = CFG_DW'(rounds_r);
      REG_KEY_LEN:   prdata = CFG_DW'(key_len_r);
      default:       prdata = '0;
    endcase
  end

  // effective size and key length, saturated into range
  logic [NW-1:0] n_eff;
  logic [NW-1:0] l_eff;

  always_comb begin
    n_eff = perm_size_r;
    if (perm_size_r < NW'(2)) n_eff = NW'(2);
    if (perm_size_r > NW'(PERM_DEPTH)) n_eff = NW'(PERM_DEPTH);
    l_eff = key_len_r;
    if (key_len_r < NW'(1)) l_eff = NW'(1);
    if (key_len_r > NW'(KEY_DEPTH)) l_eff = NW'(KEY_DEPTH);
  end

  // sequencer registers
  logic [3:0]    state_r, state_nxt;
  logic [3:0]    ret_r, ret_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] res_r, res_nxt;
  logic [7:0]    si_r, si_nxt;
  logic [XW-1:0] rem_r, rem_nxt;
  logic [1:0]    mk_r, mk_nxt;
  logic [NW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [KAW-1:0] kidx_r, kidx_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic          fwd_r, fwd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  // memory ports
  logic          pwe;
  logic [AW-1:0] pwa;
  logic [7:0]    pwd;
  logic [AW-1:0] pra;
  logic [7:0]    prd_r;
  logic          kwe;
  logic [7:0]    krd_r;

  // reduction front end: one compare and subtract when the sum is below 2n
  logic [XW-1:0] red_x;
  logic          red_fast;
  logic [AW-1:0] red_val;

  always_comb begin
    case (state_r)
      ST_IDLE:     red_x = XW'(i_r) + XW'(1);
      ST_GEN_J:    red_x = XW'(j_r) + XW'(prd_r);
      ST_GEN_SWAP: red_x = XW'(si_r) + XW'(prd_r);
      ST_SCH_J:    red_x = XW'(j_r) + XW'(prd_r) + XW'(krd_r);
      default:     red_x = '0;
    endcase
  end

  assign red_fast = red_x < {n_eff, 1'b0};
  assign red_val  = AW'(mod_fold(red_x, n_eff));

  // iterative modulo: three quotient bits per cycle, from bit 8 down
  logic [XW-1:0] mod_rem;

  always_comb begin
    mod_rem = rem_r;
    for (int s = 0; s < MOD_BITS_PER_CYC; s++) begin
      mod_rem = mod_sub(mod_rem, n_eff,
                        (MOD_BITS_PER_CYC * MOD_CYCLES - 1) -
                        MOD_BITS_PER_CYC * int'(mk_r) - s);
    end
  end

  // index increments for the schedule
  logic [NW-1:0] a_inc;
  logic [NW-1:0] kidx_inc;
  logic          last_round;

  assign a_inc      = NW'(a_r) + NW'(1);
  assign kidx_inc   = NW'(kidx_r) + NW'(1);
  assign last_round = (17'(rnd_r) + 17'd1) == 17'(rounds_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    res_nxt       = res_r;
    si_nxt        = si_r;
    rem_nxt       = rem_r;
    mk_nxt        = mk_r;
    fill_nxt      = fill_r;
    a_nxt         = a_r;
    kidx_nxt      = kidx_r;
    rnd_nxt       = rnd_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pwe           = 1'b0;
    pwa           = i_r;
    pwd           = prd_r;
    pra           = res_r;
    kwe           = 1'b0;

    // output register drains on a transfer
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        pra = red_val;
        if (in_xfer) begin
          unique case (in_opcode)
            OP_LOAD: begin
              kwe = NW'(in_key_index) < NW'(KEY_DEPTH);
            end
            OP_SCHED: begin
              fill_nxt  = '0;
              j_nxt     = '0;
              state_nxt = ST_SCH_FILL;
            end
            OP_GEN: begin
              if (red_fast) begin
                i_nxt     = red_val;
                state_nxt = ST_GEN_J;
              end else begin
                rem_nxt   = red_x;
                mk_nxt    = '0;
                ret_nxt   = ST_GEN_IRD;
                state_nxt = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end

      // generate: i known after a long reduction, read S[i]
      ST_GEN_IRD: begin
        i_nxt     = res_r;
        pra       = res_r;
        state_nxt = ST_GEN_J;
      end

      // generate: j + S[i]
      ST_GEN_J: begin
        si_nxt = prd_r;
        if (red_fast) begin
          res_nxt   = red_val;
          state_nxt = ST_GEN_JRD;
        end else begin
          rem_nxt   = red_x;
          mk_nxt    = '0;
          ret_nxt   = ST_GEN_JRD;
          state_nxt = ST_MOD;
        end
      end

      // generate: read S[j]
      ST_GEN_JRD: begin
        j_nxt     = res_r;
        pra       = res_r;
        state_nxt = ST_GEN_SWAP;
      end

      // generate: S[i] gets S[j]; output index is S[i] + S[j]
      ST_GEN_SWAP: begin
        pwe = 1'b1;
        pwa = i_r;
        pwd = prd_r;
        if (red_fast) begin
          res_nxt   = red_val;
          state_nxt = ST_GEN_T;
        end else begin
          rem_nxt   = red_x;
          mk_nxt    = '0;
          ret_nxt   = ST_GEN_T;
          state_nxt = ST_MOD;
        end
      end

      // generate: S[j] gets old S[i]; read output entry, forward the same-cycle write
      ST_GEN_T: begin
        pwe       = 1'b1;
        pwa       = j_r;
        pwd       = si_r;
        pra       = res_r;
        fwd_nxt   = res_r == j_r;
        state_nxt = ST_GEN_EMIT;
      end

      // generate: load the output register when it is free
      ST_GEN_EMIT: begin
        pra = res_r;
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = fwd_r ? si_r : prd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // schedule: identity fill
      ST_SCH_FILL: begin
        pwe      = 1'b1;
        pwa      = fill_r[AW-1:0];
        pwd      = fill_r[7:0];
        fill_nxt = fill_r + NW'(1);
        if (fill_r == n_eff - NW'(1)) begin
          a_nxt    = '0;
          kidx_nxt = '0;
          rnd_nxt  = '0;
          if (rounds_r == '0) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SCH_RD;
          end
        end
      end

      // schedule: read S[a]; key store reads at the key index every cycle
      ST_SCH_RD: begin
        pra       = a_r;
        state_nxt = ST_SCH_J;
      end

      // schedule: j + S[a] + key
      ST_SCH_J: begin
        si_nxt = prd_r;
        if (red_fast) begin
          res_nxt   = red_val;
          state_nxt = ST_SCH_JRD;
        end else begin
          rem_nxt   = red_x;
          mk_nxt    = '0;
          ret_nxt   = ST_SCH_JRD;
          state_nxt = ST_MOD;
        end
      end

      // schedule: read S[j]
      ST_SCH_JRD: begin
        j_nxt     = res_r;
        pra       = res_r;
        state_nxt = ST_SCH_SW;
      end

      // schedule: S[a] gets S[j]
      ST_SCH_SW: begin
        pwe       = 1'b1;
        pwa       = a_r;
        pwd       = prd_r;
        state_nxt = ST_SCH_W2;
      end

      // schedule: S[j] gets old S[a], advance the round
      ST_SCH_W2: begin
        pwe      = 1'b1;
        pwa      = j_r;
        pwd      = si_r;
        rnd_nxt  = rnd_r + RW'(1);
        a_nxt    = (a_inc == n_eff) ? '0 : a_inc[AW-1:0];
        kidx_nxt = (kidx_inc == l_eff) ? '0 : kidx_inc[KAW-1:0];
        if (last_round) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCH_RD;
        end
      end

      // long reduction, then back to the waiting step
      ST_MOD: begin
        if (mk_r == 2'(MOD_CYCLES - 1)) begin
          res_nxt   = AW'(mod_rem);
          state_nxt = ret_r;
        end else begin
          rem_nxt = mod_rem;
          mk_nxt  = mk_r + 2'd1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    res_r      <= res_nxt;
    si_r       <= si_nxt;
    rem_r      <= rem_nxt;
    mk_r       <= mk_nxt;
    fill_r     <= fill_nxt;
    a_r        <= a_nxt;
    kidx_r     <= kidx_nxt;
    rnd_r      <= rnd_nxt;
    fwd_r      <= fwd_nxt;
    out_data_r <= out_data_nxt;
  end

  // permutation memory, read returns the old entry on a same-address write
  logic [7:0] perm_mem [PERM_DEPTH];

  always_ff @(posedge clk) begin
    if (pwe) perm_mem[pwa] <= pwd;
    prd_r <= perm_mem[pra];
  end

  // key store
  logic [7:0] key_mem [KEY_DEPTH];

  always_ff @(posedge clk) begin
    if (kwe) key_mem[in_key_index[KAW-1:0]] <= in_key_value;
    krd_r <= key_mem[kidx_r];
  end

  // stream handshakes
  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the output register is never overwritten while a value waits
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_EMIT && out_valid_r && !out_tready) |=>
      (state_r == ST_GEN_EMIT && $stable(out_data_r)))
    else $error("keystream register overwritten while stalled");

  // reduced j stays below the permutation size
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_JRD || state_r == ST_SCH_JRD) |-> (NW'(res_r) < n_eff))
    else $error("reduced index out of range");

  // fill never runs past the permutation size
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCH_FILL) |-> (fill_r < n_eff))
    else $error("identity fill out of range");

  // long reduction finishes within its cycle budget
  a_mod_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> (mk_r < 2'(MOD_CYCLES)))
    else $error("modulo unit phase overrun");

endmodule
